// ----- design/rit_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rit_pkg: shared definitions for the reference-counted key table
// Holds table sizes, field widths, status codes, controller states and the
// command and status bundles that pass between the controller and datapath.
// ----------------------------------------------------------------------------
package rit_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int KEY_W       = 32;
    localparam int CNT_W       = 16;
    localparam int SLOT_W      = 6;
    localparam int STATUS_W    = 3;
    localparam int ENTRY_W     = KEY_W + CNT_W;
    localparam int OUT_W       = STATUS_W + SLOT_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic [0:0] MODE_OPEN  = 1'b0;
    localparam logic [0:0] MODE_CLOSE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_JOINED   = 3'd0,
        ST_CREATED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_SHARED   = 3'd3,
        ST_FREED    = 3'd4,
        ST_NOTFOUND = 3'd5,
        ST_BADKEY   = 3'd6,
        ST_OVERFLOW = 3'd7
    } status_code_t;

    typedef enum logic [1:0] {
        CTRL_IDLE,
        CTRL_SCAN,
        CTRL_COMMIT
    } ctrl_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic accept;   // latch the request and restart the scan
        logic scan;     // walk the table
        logic commit;   // apply the update and load the result register
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_done;  // every entry has been compared
        logic out_free;   // the result register can take a new result
    } dp_status_t;

endpackage
`default_nettype wire

// ----- design/rit_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rit_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are not reset.
// ----------------------------------------------------------------------------
module rit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- design/rit_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rit_ctrl: request sequencer for the key table
// Accepts a request, runs the table scan, then commits once the result
// register is free.
// ----------------------------------------------------------------------------
module rit_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire rit_pkg::dp_status_t sts,
    output rit_pkg::ctrl_cmd_t       cmd
);

    rit_pkg::ctrl_state_t state_reg;
    rit_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rit_pkg::CTRL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            rit_pkg::CTRL_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = rit_pkg::CTRL_SCAN;
                end
            end
            rit_pkg::CTRL_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = rit_pkg::CTRL_COMMIT;
                end
            end
            rit_pkg::CTRL_COMMIT: begin
                // Hold here while an earlier result is still waiting.
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = rit_pkg::CTRL_IDLE;
                end
            end
            default: begin
                state_next = rit_pkg::CTRL_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- design/rit_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rit_datapath: entry storage, table scan and result register
// Entries live in a RAM; a valid bit per entry makes unwritten or freed
// entries read as free. The scan records the first matching and first free
// entry, and the commit step updates the table and forms the result.
// ----------------------------------------------------------------------------
module rit_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire rit_pkg::ctrl_cmd_t              cmd,
    output rit_pkg::dp_status_t                  sts,
    input  wire logic [0:0]                     s_tuser,
    input  wire logic [rit_pkg::KEY_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [rit_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int IDX_W = rit_pkg::IDX_W;
    localparam int KEY_W = rit_pkg::KEY_W;
    localparam int CNT_W = rit_pkg::CNT_W;
    localparam logic [IDX_W:0] SCAN_END = (IDX_W + 1)'(rit_pkg::TABLE_DEPTH);

    // Request.
    logic [0:0]       mode_reg;
    logic [KEY_W-1:0] key_reg;

    // Scan.
    logic [IDX_W:0]   issue_cnt_reg;
    logic             cmp_valid_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             cmp_live_reg;
    logic             issuing;

    logic [rit_pkg::TABLE_DEPTH-1:0] valid_reg;

    logic             found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic [CNT_W-1:0] match_cnt_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // RAM.
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    logic [rit_pkg::ENTRY_W-1:0]  wr_data;
    logic [rit_pkg::ENTRY_W-1:0]  rd_data;
    logic [KEY_W-1:0]             rd_key;
    logic [CNT_W-1:0]             rd_cnt;

    // Commit.
    rit_pkg::status_code_t        res_status;
    logic [IDX_W-1:0]             res_idx;
    logic [CNT_W-1:0]             res_cnt;
    logic                         set_valid;
    logic                         clr_valid;

    logic                          out_valid_reg;
    logic [rit_pkg::STATUS_W-1:0]  out_status_reg;
    logic [rit_pkg::SLOT_W-1:0]    out_slot_reg;
    logic [CNT_W-1:0]              out_cnt_reg;

    assign issuing = cmd.scan && (issue_cnt_reg != SCAN_END);
    assign rd_key  = rd_data[rit_pkg::ENTRY_W-1:CNT_W];
    assign rd_cnt  = rd_data[CNT_W-1:0];

    rit_ram #(
        .WIDTH(rit_pkg::ENTRY_W),
        .DEPTH(rit_pkg::TABLE_DEPTH)
    ) u_entry_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (issuing),
        .rd_addr(issue_cnt_reg[IDX_W-1:0]),
        .rd_data(rd_data)
    );

    // Request capture and scan bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_cnt_reg  <= '0;
            cmp_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmd.accept) begin
            issue_cnt_reg  <= '0;
            cmp_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            if (issuing) begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
            end
            cmp_valid_reg <= issuing;
            if (cmp_valid_reg) begin
                if (cmp_live_reg && (rd_key == key_reg) && !found_reg) begin
                    found_reg <= 1'b1;
                end
                if (!cmp_live_reg && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mode_reg <= s_tuser;
            key_reg  <= s_tdata;
        end
        if (issuing) begin
            cmp_idx_reg  <= issue_cnt_reg[IDX_W-1:0];
            cmp_live_reg <= valid_reg[issue_cnt_reg[IDX_W-1:0]];
        end
        if (cmp_valid_reg) begin
            if (cmp_live_reg && (rd_key == key_reg) && !found_reg) begin
                match_idx_reg <= cmp_idx_reg;
                match_cnt_reg <= rd_cnt;
            end
            if (!cmp_live_reg && !free_found_reg) begin
                free_idx_reg <= cmp_idx_reg;
            end
        end
    end

    assign sts.scan_done = (issue_cnt_reg == SCAN_END) && !cmp_valid_reg;
    assign sts.out_free  = !out_valid_reg || m_tready;

    // Decision for the committed request.
    always_comb begin
        res_status = rit_pkg::ST_BADKEY;
        res_idx    = '0;
        res_cnt    = '0;
        wr_en      = 1'b0;
        wr_addr    = match_idx_reg;
        wr_data    = '0;
        set_valid  = 1'b0;
        clr_valid  = 1'b0;
        if (key_reg == '0) begin
            res_status = rit_pkg::ST_BADKEY;
        end else if (mode_reg == rit_pkg::MODE_OPEN) begin
            if (found_reg) begin
                res_idx = match_idx_reg;
                if (match_cnt_reg == rit_pkg::COUNT_MAX) begin
                    res_status = rit_pkg::ST_OVERFLOW;
                    res_cnt    = match_cnt_reg;
                end else begin
                    res_status = rit_pkg::ST_JOINED;
                    res_cnt    = match_cnt_reg + 1'b1;
                    wr_en      = cmd.commit;
                    wr_data    = {key_reg, res_cnt};
                end
            end else if (free_found_reg) begin
                res_status = rit_pkg::ST_CREATED;
                res_idx    = free_idx_reg;
                res_cnt    = CNT_W'(1);
                wr_en      = cmd.commit;
                wr_addr    = free_idx_reg;
                wr_data    = {key_reg, res_cnt};
                set_valid  = cmd.commit;
            end else begin
                res_status = rit_pkg::ST_FULL;
            end
        end else begin
            if (!found_reg) begin
                res_status = rit_pkg::ST_NOTFOUND;
            end else if (match_cnt_reg > CNT_W'(1)) begin
                res_status = rit_pkg::ST_SHARED;
                res_idx    = match_idx_reg;
                res_cnt    = match_cnt_reg - 1'b1;
                wr_en      = cmd.commit;
                wr_data    = {key_reg, res_cnt};
            end else begin
                // Freeing only drops the valid bit; the entry then reads as free.
                res_status = rit_pkg::ST_FREED;
                res_idx    = match_idx_reg;
                clr_valid  = cmd.commit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (set_valid) begin
            valid_reg[free_idx_reg] <= 1'b1;
        end else if (clr_valid) begin
            valid_reg[match_idx_reg] <= 1'b0;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_status_reg <= res_status;
            out_slot_reg   <= rit_pkg::SLOT_W'(res_idx);
            out_cnt_reg    <= res_cnt;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(rit_pkg::OUT_TDATA_W - rit_pkg::OUT_W){1'b0}},
                       out_cnt_reg, out_slot_reg, out_status_reg};

endmodule
`default_nettype wire

// ----- design/refcounted_id_table_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_id_table_unit: reference-counted key table
// The input stream carries open and close requests: s_tuser[0] is the mode
// (0 open or share, 1 close) and s_tdata is the 32-bit key. Each request gives
// exactly one result on the output stream: status, slot index and the
// entry's reference count after the operation.
// A request is taken only while the unit is idle. The unit then walks all 64
// entries through the entry RAM, one read a cycle, remembering the first
// matching entry and the lowest free entry, and then commits the update.
// The unit returns to idle after the commit and only then takes the next
// request, so requests do not overlap; the single RAM read port and the
// full table walk set how long each request takes.
// The result sits in an output register, so a new request is accepted while
// an earlier result still waits; if the receiver is still stalled when the
// next commit is due, the unit holds in its commit state until the result
// register is taken.
// Reset clears every entry's valid bit at once, so the table reads as empty
// right after reset with no clearing pass; the unit is ready as soon as
// aresetn is released.
// ----------------------------------------------------------------------------
module refcounted_id_table_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Request channel.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [rit_pkg::KEY_W-1:0]      s_tdata,  // [31:0] key
    input  wire logic [0:0]                     s_tuser,  // [0] mode
    // Result channel.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [2:0] status, [8:3] slot, [24:9] ref_count, [31:25] zero
    output logic [rit_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    rit_pkg::ctrl_cmd_t  cmd;
    rit_pkg::dp_status_t sts;

    // The controller sequences accept, scan and commit.
    rit_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds the table, the scan and the result register.
    rit_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule
`default_nettype wire

// ----- sim/tb_refcounted_id_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_refcounted_id_table_unit: self-checking bench for the key table
// Sends open and close requests through the request stream while a bit-true
// table model predicts the status, slot and count of every result. Each result
// taken from the result stream is compared with the oldest prediction. Both
// streams idle at random, and the table is filled, overfilled and drained.
// ----------------------------------------------------------------------------
module tb_refcounted_id_table_unit;
    import rit_pkg::*;

    localparam int CLK_HALF_NS  = 5;
    localparam int RESET_CYCLES = 8;
    // The limit allows for a run of about 900 requests with the longest result
    // stalls and sender idles in the worst case.
    localparam int LIMIT_CYCLES = 1_500_000;
    // Quiet period after the last result: longer than one full request.
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        int unsigned        req_id;
        logic               mode;
        logic [KEY_W-1:0]   key;
        status_code_t       status;
        logic [SLOT_W-1:0]  slot;
        logic [CNT_W-1:0]   ref_count;
    } table_result_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [KEY_W-1:0]       s_tdata  = '0;   // [31:0] key
    logic [0:0]             s_tuser  = '0;   // [0] mode
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // [2:0] status, [8:3] slot, [24:9] ref_count

    // Bench copy of the table, updated when each request is accepted.
    logic [KEY_W-1:0] table_key   [TABLE_DEPTH];
    logic [CNT_W-1:0] table_count [TABLE_DEPTH];
    table_result_t    pending_results [$];

    int unsigned requests_sent     = 0;
    int unsigned requests_accepted = 0;
    int unsigned results_seen      = 0;
    int unsigned mismatch_count    = 0;
    int unsigned cycle_count       = 0;
    int unsigned status_seen [8]   = '{default: 0};

    // Sender pacing: bursts of up to burst_max requests, gaps of up to gap_max, now and then a longer one.
    int burst_left = 0;
    int burst_max  = 1;
    int gap_max    = 0;
    int rx_left    = 0;

    refcounted_id_table_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #CLK_HALF_NS aclk = 1'b1;
        #CLK_HALF_NS aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: ready runs of varied length; now and then a stall longer than
    // a whole request, so the unit has to hold its commit until the result
    // register is taken.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            if (m_tready) begin
                rx_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(69, 100))
                                                      : int'($urandom_range(1, 6));
                m_tready <= 1'b0;
            end else begin
                rx_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(100, 400))
                                                      : int'($urandom_range(1, 40));
                m_tready <= 1'b1;
            end
        end else begin
            rx_left = rx_left - 1;
        end
    end

    // Applies one request to the bench table and returns the expected result.
    // The first matching entry wins; a new key takes the lowest free entry.
    function automatic table_result_t predict_table_update(input logic mode,
                                                          input logic [KEY_W-1:0] key);
        table_result_t r;
        int hit;
        int free_slot;
        int i;
        hit       = -1;
        free_slot = -1;
        r.req_id    = 0;
        r.mode      = mode;
        r.key       = key;
        r.status    = ST_BADKEY;
        r.slot      = '0;
        r.ref_count = '0;
        if (key == '0)
            return r;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            if (hit < 0 && table_key[i] == key)
                hit = i;
            if (free_slot < 0 && table_key[i] == '0)
                free_slot = i;
        end
        if (mode == MODE_OPEN) begin
            if (hit >= 0) begin
                r.slot = SLOT_W'(hit);
                if (table_count[hit] == COUNT_MAX) begin
                    // A saturated count refuses the open and leaves the entry as it is.
                    r.status    = ST_OVERFLOW;
                    r.ref_count = COUNT_MAX;
                end else begin
                    table_count[hit] = table_count[hit] + 1'b1;
                    r.status    = ST_JOINED;
                    r.ref_count = table_count[hit];
                end
            end else if (free_slot >= 0) begin
                table_key[free_slot]   = key;
                table_count[free_slot] = CNT_W'(1);
                r.status    = ST_CREATED;
                r.slot      = SLOT_W'(free_slot);
                r.ref_count = CNT_W'(1);
            end else begin
                r.status = ST_FULL;
            end
        end else if (hit < 0) begin
            r.status = ST_NOTFOUND;
        end else if (table_count[hit] > CNT_W'(1)) begin
            table_count[hit] = table_count[hit] - 1'b1;
            r.status    = ST_SHARED;
            r.slot      = SLOT_W'(hit);
            r.ref_count = table_count[hit];
        end else begin
            // Last reference, or a count already at zero: the entry is freed.
            table_key[hit]   = '0;
            table_count[hit] = '0;
            r.status = ST_FREED;
            r.slot   = SLOT_W'(hit);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned req_id,
                                   input longint unsigned got, input longint unsigned want_v);
        $display("MISMATCH %s, request %0d: got 0x%0h, expected 0x%0h",
                 what, req_id, got, want_v);
        mismatch_count++;
    endtask

    // Requests are predicted before results are checked, both from values
    // sampled at the same rising edge.
    always @(posedge aclk) begin : result_check
        table_result_t       want;
        logic [STATUS_W-1:0] got_status;
        logic [SLOT_W-1:0]   got_slot;
        logic [CNT_W-1:0]    got_count;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want        = predict_table_update(s_tuser[0], s_tdata);
                want.req_id = requests_accepted;
                requests_accepted++;
                pending_results.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got_status = m_tdata[STATUS_W-1:0];
                got_slot   = m_tdata[STATUS_W +: SLOT_W];
                got_count  = m_tdata[STATUS_W+SLOT_W +: CNT_W];
                results_seen++;
                status_seen[got_status]++;
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no request outstanding", results_seen,
                                    got_status, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (got_status !== want.status)
                        report_mismatch("status", want.req_id, got_status, want.status);
                    if (got_slot !== want.slot)
                        report_mismatch("slot", want.req_id, got_slot, want.slot);
                    if (got_count !== want.ref_count)
                        report_mismatch("ref_count", want.req_id, got_count, want.ref_count);
                end
            end
        end
    end

    // Sends one request; the valid stays high across a burst and drops for
    // a random gap between bursts.
    task automatic send_request(input logic mode, input logic [KEY_W-1:0] key);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max > 0 && $urandom_range(0, 7) == 0) ? int'($urandom_range(20, 90))
                                                             : int'($urandom_range(0, gap_max));
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= key;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    // Holds the request stream idle until every predicted result has arrived.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    // Key zero, unknown keys, the key extremes, sharing, freeing and reuse of
    // the lowest free entry. Reaching the count ceiling would take 65535 opens
    // of one key, so that path is only modeled.
    task automatic test_directed();
        send_request(MODE_OPEN,  32'h0000_0000);
        send_request(MODE_CLOSE, 32'h0000_0000);
        send_request(MODE_CLOSE, 32'h1234_5678);
        send_request(MODE_OPEN,  32'hFFFF_FFFF);
        send_request(MODE_OPEN,  32'hFFFF_FFFF);
        send_request(MODE_OPEN,  32'h0000_0001);
        send_request(MODE_OPEN,  32'h8000_0000);
        send_request(MODE_CLOSE, 32'hFFFF_FFFF);
        send_request(MODE_CLOSE, 32'hFFFF_FFFF);
        send_request(MODE_CLOSE, 32'hFFFF_FFFF);
        send_request(MODE_OPEN,  32'h0000_0001);
        send_request(MODE_OPEN,  32'hA5A5_A5A5);
        send_request(MODE_OPEN,  32'h0000_0000);
        send_request(MODE_CLOSE, 32'h0000_0001);
        send_request(MODE_CLOSE, 32'h0000_0001);
        send_request(MODE_CLOSE, 32'h8000_0000);
        send_request(MODE_CLOSE, 32'hA5A5_A5A5);
        send_request(MODE_CLOSE, 32'h0000_0000);
        wait_drained();
    endtask

    // Fills every free entry with new keys, tries more while the table is
    // full, then closes every reference held in the table in random order.
    task automatic test_fill_and_drain();
        logic [KEY_W-1:0] fresh   [$];
        logic [KEY_W-1:0] closing [$];
        logic [KEY_W-1:0] k;
        int  free_slots;
        int  i;
        int  j;
        bit  clash;
        wait_drained();
        free_slots = 0;
        for (i = 0; i < TABLE_DEPTH; i++)
            if (table_key[i] == '0)
                free_slots++;
        while (fresh.size() < free_slots + 3) begin
            k     = $urandom();
            clash = (k == '0);
            for (i = 0; i < TABLE_DEPTH; i++)
                if (table_key[i] == k)
                    clash = 1'b1;
            for (i = 0; i < fresh.size(); i++)
                if (fresh[i] == k)
                    clash = 1'b1;
            if (!clash)
                fresh.push_back(k);
        end
        // The last three opens find no free entry.
        for (i = 0; i < fresh.size(); i++)
            send_request(MODE_OPEN, fresh[i]);
        // A key that never got in is not found; a resident key still joins.
        send_request(MODE_CLOSE, fresh[free_slots]);
        send_request(MODE_OPEN, fresh[0]);
        wait_drained();
        for (i = 0; i < TABLE_DEPTH; i++)
            for (j = 0; j < int'(table_count[i]); j++)
                closing.push_back(table_key[i]);
        for (i = closing.size() - 1; i > 0; i--) begin
            j          = $urandom_range(0, i);
            k          = closing[i];
            closing[i] = closing[j];
            closing[j] = k;
        end
        for (i = 0; i < closing.size(); i++)
            send_request(MODE_CLOSE, closing[i]);
    endtask

    // Opens and closes drawn from a pool of keys, so that most requests hit
    // live entries, with key zero and unknown keys mixed in. A large pool
    // with more opens than closes keeps the table full much of the time.
    task automatic test_random_traffic(input int items, input int pool_size,
                                       input int open_pct);
        logic [KEY_W-1:0] pool [$];
        int n;
        int pick;
        pool.push_back(32'hFFFF_FFFF);
        pool.push_back(32'h0000_0001);
        pool.push_back(32'h8000_0000);
        while (pool.size() < pool_size)
            pool.push_back($urandom() | 32'h1);
        for (n = 0; n < items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_request(1'($urandom_range(0, 1)), '0);
            else if (pick < 9)
                send_request(1'($urandom_range(0, 1)), $urandom());
            else if (pick < 9 + open_pct)
                send_request(MODE_OPEN, pool[$urandom_range(0, pool_size - 1)]);
            else
                send_request(MODE_CLOSE, pool[$urandom_range(0, pool_size - 1)]);
            if (n == items / 2)
                wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        int i;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            table_key[i]   = '0;
            table_count[i] = '0;
        end
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        burst_max = 1;  gap_max = 0;  test_directed();
        burst_max = 8;  gap_max = 4;  test_fill_and_drain();
        burst_max = 16; gap_max = 0;  test_random_traffic(200, 12, 50);
        burst_max = 4;  gap_max = 30; test_random_traffic(200, 96, 62);
        burst_max = 8;  gap_max = 6;  test_random_traffic(200, 40, 47);
        burst_max = 32; gap_max = 2;  test_fill_and_drain();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d requests and %0d results in %0d cycles, %0d mismatches",
                 requests_sent, results_seen, cycle_count, mismatch_count);
        $display("Statuses: joined %0d created %0d full %0d shared %0d freed %0d %s %0d",
                 status_seen[ST_JOINED], status_seen[ST_CREATED], status_seen[ST_FULL],
                 status_seen[ST_SHARED], status_seen[ST_FREED], "not found",
                 status_seen[ST_NOTFOUND]);
        $display("          bad key %0d count overflow %0d",
                 status_seen[ST_BADKEY], status_seen[ST_OVERFLOW]);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
